@@ hdl/line_trace_command_sequencer_defines.svh @@
// Assertion macros shared by the line trace command sequencer modules.
// Bodies refer to clk and arst_n of the module that uses them.
`ifndef LINE_TRACE_COMMAND_SEQUENCER_DEFINES_SVH
`define LINE_TRACE_COMMAND_SEQUENCER_DEFINES_SVH

// Condition must hold at every rising clock edge outside reset.
`define LTCS_CHECK(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define LTCS_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ hdl/ltcs_pkg.sv @@
// Types and constants of the line trace command sequencer.
// No dependencies; every module of the block imports it.
package ltcs_pkg;

	localparam int SumW     = 24;
	localparam int CountW   = 14;
	localparam int LevelW   = 10;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 14;

	// Forward command source select
	localparam logic [2:0] FWD_HOLD   = 3'd0;
	localparam logic [2:0] FWD_ZERO   = 3'd1;
	localparam logic [2:0] FWD_CRUISE = 3'd2;
	localparam logic [2:0] FWD_DASH   = 3'd3;
	localparam logic [2:0] FWD_BACK   = 3'd4;

	typedef struct packed {
		logic               opcode;
		logic               touch_pressed;
		logic [9:0]         gyro_sample;
		logic [9:0]         light_sample;
		logic signed [31:0] wheel_count;
		logic [31:0]        time_ms;
	} item_t;

	typedef struct packed {
		logic signed [7:0] forward_cmd;
		logic signed [7:0] turn_cmd;
		logic              in_control;
		logic [9:0]        offset_value;
		logic [2:0]        tone_code;
		logic [3:0]        step_code;
	} result_t;

	typedef struct packed {
		logic [9:0]  steer_gain_q8;
		logic [6:0]  cruise_speed;
		logic [6:0]  dash_speed;
		logic [9:0]  slope_gyro_limit;
		logic [9:0]  summit_gyro_limit;
		logic [11:0] backoff_min_counts;
		logic [11:0] backoff_max_counts;
		logic [13:0] window_ms;
	} cfg_t;

	// Controller to datapath
	typedef struct packed {
		logic       capture;
		logic       sum_clear;
		logic       sum_add;
		logic       time_mark;
		logic       div_start;
		logic       offset_load;
		logic       black_load;
		logic       white_load;
		logic       mul;
		logic       turn_load;
		logic       turn_zero;
		logic [2:0] fwd_sel;
		logic       mark_load;
		logic       out_load;
		logic [2:0] tone;
		logic [3:0] step;
		logic       in_control;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic opcode;
		logic touch;
		logic window_done;
		logic count_full;
		logic crash_gyro;
		logic summit_gyro;
		logic dash_window;
		logic clear_window;
		logic div_done;
	} sts_t;

endpackage

@@ hdl/ltcs_cfg.sv @@
// Configuration register file of the line trace command sequencer.
// Depends on ltcs_pkg for the register struct and port widths.
module ltcs_cfg
	import ltcs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	output cfg_t                cfg
);

	localparam logic [CfgIdxW-1:0] REG_GAIN      = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_CRUISE    = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_DASH      = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_SLOPE     = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_SUMMIT    = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_BACK_MIN  = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_BACK_MAX  = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_WINDOW    = 3'd7;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.steer_gain_q8      <= 10'd179;
			cfg_q.cruise_speed       <= 7'd20;
			cfg_q.dash_speed         <= 7'd75;
			cfg_q.slope_gyro_limit   <= 10'd650;
			cfg_q.summit_gyro_limit  <= 10'd700;
			cfg_q.backoff_min_counts <= 12'd90;
			cfg_q.backoff_max_counts <= 12'd720;
			cfg_q.window_ms          <= 14'd1000;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_GAIN:     cfg_q.steer_gain_q8      <= cfg_data[9:0];
				REG_CRUISE:   cfg_q.cruise_speed       <= cfg_data[6:0];
				REG_DASH:     cfg_q.dash_speed         <= cfg_data[6:0];
				REG_SLOPE:    cfg_q.slope_gyro_limit   <= cfg_data[9:0];
				REG_SUMMIT:   cfg_q.summit_gyro_limit  <= cfg_data[9:0];
				REG_BACK_MIN: cfg_q.backoff_min_counts <= cfg_data[11:0];
				REG_BACK_MAX: cfg_q.backoff_max_counts <= cfg_data[11:0];
				REG_WINDOW:   cfg_q.window_ms          <= cfg_data[13:0];
				default: ;
			endcase
		end
	end

endmodule

@@ hdl/ltcs_div.sv @@
// Restoring divider, one quotient bit per cycle, for the gyro average.
// Depends on ltcs_pkg for the sum and count widths.
module ltcs_div
	import ltcs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SumW-1:0]   dividend,
	input  logic [CountW-1:0] divisor,
	output logic [SumW-1:0]   quotient,
	output logic              done
);

	localparam int DivSteps = SumW;
	localparam int CntW     = $clog2(DivSteps + 1);

	logic              busy_q;
	logic              done_q;
	logic [CntW-1:0]   cnt_q;
	logic [CountW-1:0] rem_q;
	logic [SumW-1:0]   quo_q;
	logic [CountW:0]   shifted;
	logic [CountW:0]   diff;
	logic              fits;

	assign shifted = {rem_q, quo_q[SumW-1]};
	assign diff    = shifted - {1'b0, divisor};
	assign fits    = shifted >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CntW'(DivSteps);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CntW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[CountW-1:0] : shifted[CountW-1:0];
			quo_q <= {quo_q[SumW-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

@@ hdl/ltcs_datapath.sv @@
// Datapath: sample registers, gyro accumulator, steering multiply and clamp,
// slope comparisons and the result register. Uses ltcs_pkg and ltcs_div.
module ltcs_datapath
	import ltcs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item,
	input  cfg_t    cfg,
	input  cmd_t    cmd,
	output sts_t    sts,
	output result_t result
);

	localparam int                BackoffSpeed = 20;
	localparam int                TurnLimit    = 100;
	localparam logic signed [33:0] ClearCounts = 34'sd90;
	localparam logic [CountW-1:0] CountMax     = '1;

	item_t              item_q;
	result_t            result_q;
	logic [31:0]        start_q;
	logic [SumW-1:0]    sum_q;
	logic [CountW-1:0]  count_q;
	logic [LevelW-1:0]  offset_q;
	logic [LevelW-1:0]  black_q;
	logic [LevelW-1:0]  white_q;
	logic signed [31:0] mark_q;
	logic signed [7:0]  fwd_q;
	logic signed [7:0]  turn_q;
	logic signed [21:0] prod_s1;

	logic [LevelW:0]    level_sum;
	logic signed [10:0] dev;
	logic signed [21:0] prod;
	logic [21:0]        prod_mag;
	logic [13:0]        turn_mag;
	logic [6:0]         turn_sat;
	logic signed [7:0]  turn_val;
	logic [31:0]        elapsed;
	logic signed [33:0] wheel_x;
	logic signed [33:0] mark_x;
	logic signed [33:0] min_x;
	logic signed [33:0] max_x;
	logic [SumW-1:0]    div_quo;
	logic               div_done;

	ltcs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_q),
		.divisor  (count_q),
		.quotient (div_quo),
		.done     (div_done)
	);

	// Steering: midpoint of the two levels minus the light reading, times gain
	assign level_sum = {1'b0, black_q} + {1'b0, white_q};
	assign dev       = $signed({1'b0, level_sum[LevelW:1]}) - $signed({1'b0, item_q.light_sample});
	assign prod      = $signed({1'b0, cfg.steer_gain_q8}) * dev;

	// Truncate toward zero, then clamp the magnitude
	assign prod_mag = prod_s1[21] ? 22'(-prod_s1) : 22'(prod_s1);
	assign turn_mag = prod_mag[21:8];
	assign turn_sat = (turn_mag > 14'(TurnLimit)) ? 7'(TurnLimit) : turn_mag[6:0];
	assign turn_val = prod_s1[21] ? 8'(-{1'b0, turn_sat}) : {1'b0, turn_sat};

	assign elapsed = item_q.time_ms - start_q;

	assign wheel_x = {{2{item_q.wheel_count[31]}}, item_q.wheel_count};
	assign mark_x  = {{2{mark_q[31]}}, mark_q};
	assign min_x   = $signed({22'd0, cfg.backoff_min_counts});
	assign max_x   = $signed({22'd0, cfg.backoff_max_counts});

	always_comb begin
		sts.opcode       = item_q.opcode;
		sts.touch        = item_q.touch_pressed;
		sts.window_done  = elapsed >= {18'd0, cfg.window_ms};
		sts.count_full   = count_q == CountMax;
		sts.crash_gyro   = item_q.gyro_sample > cfg.slope_gyro_limit;
		sts.summit_gyro  = item_q.gyro_sample > cfg.summit_gyro_limit;
		sts.dash_window  = (wheel_x < mark_x - min_x) && (wheel_x > mark_x - max_x);
		sts.clear_window = wheel_x > mark_x + ClearCounts;
		sts.div_done     = div_done;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
		if (cmd.mul) begin
			prod_s1 <= prod;
		end
		if (cmd.out_load) begin
			result_q.forward_cmd  <= fwd_q;
			result_q.turn_cmd     <= turn_q;
			result_q.in_control   <= cmd.in_control;
			result_q.offset_value <= offset_q;
			result_q.tone_code    <= cmd.tone;
			result_q.step_code    <= cmd.step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= '0;
			sum_q    <= '0;
			count_q  <= '0;
			offset_q <= '0;
			black_q  <= '0;
			white_q  <= '0;
			mark_q   <= '0;
			fwd_q    <= '0;
			turn_q   <= '0;
		end else begin
			if (cmd.time_mark) begin
				start_q <= item_q.time_ms;
			end
			if (cmd.sum_clear) begin
				sum_q   <= '0;
				count_q <= '0;
			end else if (cmd.sum_add) begin
				sum_q   <= sum_q + {{(SumW - LevelW){1'b0}}, item_q.gyro_sample};
				count_q <= count_q + 1'b1;
			end
			if (cmd.offset_load) begin
				offset_q <= div_quo[LevelW-1:0];
			end
			if (cmd.black_load) begin
				black_q <= item_q.light_sample;
			end
			if (cmd.white_load) begin
				white_q <= item_q.light_sample;
			end
			if (cmd.mark_load) begin
				mark_q <= item_q.wheel_count;
			end
			if (cmd.turn_zero) begin
				turn_q <= '0;
			end else if (cmd.turn_load) begin
				turn_q <= turn_val;
			end
			case (cmd.fwd_sel)
				FWD_ZERO:   fwd_q <= '0;
				FWD_CRUISE: fwd_q <= {1'b0, cfg.cruise_speed};
				FWD_DASH:   fwd_q <= {1'b0, cfg.dash_speed};
				FWD_BACK:   fwd_q <= 8'(-BackoffSpeed);
				default: ;
			endcase
		end
	end

	assign result = result_q;

endmodule

@@ hdl/ltcs_ctrl.sv @@
// Controller: tick sequencing, calibration steps, slope flags and handshakes.
// Depends on ltcs_pkg and the assertion macros header.
`include "line_trace_command_sequencer_defines.svh"

module ltcs_ctrl
	import ltcs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_stall,
	output logic result_valid,
	input  logic result_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [3:0] PH_IDLE    = 4'd0;
	localparam logic [3:0] PH_DECODE  = 4'd1;
	localparam logic [3:0] PH_CAL     = 4'd2;
	localparam logic [3:0] PH_DIVGO   = 4'd3;
	localparam logic [3:0] PH_DIVWAIT = 4'd4;
	localparam logic [3:0] PH_MUL     = 4'd5;
	localparam logic [3:0] PH_CRASH   = 4'd6;
	localparam logic [3:0] PH_DASH    = 4'd7;
	localparam logic [3:0] PH_SUMMIT  = 4'd8;
	localparam logic [3:0] PH_CLEAR   = 4'd9;
	localparam logic [3:0] PH_DONE    = 4'd10;

	localparam logic [3:0] STEP_GYRO_START = 4'd0;
	localparam logic [3:0] STEP_GYRO       = 4'd1;
	localparam logic [3:0] STEP_GYRO_END   = 4'd2;
	localparam logic [3:0] STEP_OK         = 4'd3;
	localparam logic [3:0] STEP_OK_END     = 4'd4;
	localparam logic [3:0] STEP_END        = 4'd5;
	localparam logic [3:0] STEP_BLACK      = 4'd6;
	localparam logic [3:0] STEP_WHITE      = 4'd7;
	localparam logic [3:0] STEP_HOLD       = 4'd8;

	localparam logic [2:0] TONE_NONE      = 3'd0;
	localparam logic [2:0] TONE_START     = 3'd1;
	localparam logic [2:0] TONE_GYRO_DONE = 3'd2;
	localparam logic [2:0] TONE_CAPTURE   = 3'd3;
	localparam logic [2:0] TONE_CRASH     = 3'd4;
	localparam logic [2:0] TONE_DASH      = 3'd5;
	localparam logic [2:0] TONE_SUMMIT    = 3'd6;

	logic [3:0] phase_q, phase_d;
	logic [3:0] cal_step_q, cal_step_d;
	logic [2:0] tone_q, tone_d;
	logic       hold_to_ok_q, hold_to_ok_d;
	logic       control_mode_q, control_mode_d;
	logic       slope_armed_q, slope_armed_d;
	logic       backing_off_q, backing_off_d;
	logic       dashing_q, dashing_d;
	logic       result_valid_q;

	assign item_stall   = phase_q != PH_IDLE;
	assign result_valid = result_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.fwd_sel    = FWD_HOLD;
		cmd.tone       = tone_q;
		cmd.step       = cal_step_q;
		cmd.in_control = control_mode_q;
		phase_d        = phase_q;
		cal_step_d     = cal_step_q;
		tone_d         = tone_q;
		hold_to_ok_d   = hold_to_ok_q;
		control_mode_d = control_mode_q;
		slope_armed_d  = slope_armed_q;
		backing_off_d  = backing_off_q;
		dashing_d      = dashing_q;

		unique case (phase_q)
			PH_IDLE: begin
				if (item_valid) begin
					cmd.capture = 1'b1;
					phase_d     = PH_DECODE;
				end
			end
			PH_DECODE: begin
				tone_d = TONE_NONE;
				if (sts.opcode) begin
					phase_d = PH_MUL;
				end else if (control_mode_q) begin
					phase_d = PH_DONE;
				end else begin
					phase_d = PH_CAL;
				end
			end
			PH_CAL: begin
				cmd.turn_zero = 1'b1;
				cmd.fwd_sel   = FWD_ZERO;
				phase_d       = PH_DONE;
				unique case (cal_step_q)
					STEP_GYRO_START: begin
						if (sts.touch) begin
							tone_d        = TONE_START;
							cmd.sum_clear = 1'b1;
							cmd.time_mark = 1'b1;
							cal_step_d    = STEP_GYRO;
						end
					end
					STEP_GYRO: begin
						// stop counting once the count saturates
						cmd.sum_add = !sts.count_full;
						if (sts.window_done) begin
							phase_d = PH_DIVGO;
						end
					end
					STEP_GYRO_END: begin
						if (!sts.touch) begin
							cal_step_d = STEP_BLACK;
						end
					end
					STEP_BLACK: begin
						if (sts.touch) begin
							cmd.black_load = 1'b1;
							cmd.time_mark  = 1'b1;
							hold_to_ok_d   = 1'b0;
							tone_d         = TONE_CAPTURE;
							cal_step_d     = STEP_HOLD;
						end
					end
					STEP_WHITE: begin
						if (sts.touch) begin
							cmd.white_load = 1'b1;
							cmd.time_mark  = 1'b1;
							hold_to_ok_d   = 1'b1;
							tone_d         = TONE_CAPTURE;
							cal_step_d     = STEP_HOLD;
						end
					end
					STEP_HOLD: begin
						if (sts.window_done) begin
							cal_step_d = hold_to_ok_q ? STEP_OK : STEP_WHITE;
						end
					end
					STEP_OK: begin
						if (sts.touch) begin
							tone_d     = TONE_START;
							cal_step_d = STEP_OK_END;
						end
					end
					STEP_OK_END: begin
						if (!sts.touch) begin
							tone_d     = TONE_START;
							cal_step_d = STEP_END;
						end
					end
					STEP_END: begin
						control_mode_d = 1'b1;
						slope_armed_d  = 1'b1;
					end
					default: ;
				endcase
			end
			PH_DIVGO: begin
				cmd.div_start = 1'b1;
				phase_d       = PH_DIVWAIT;
			end
			PH_DIVWAIT: begin
				if (sts.div_done) begin
					cmd.offset_load = 1'b1;
					tone_d          = TONE_GYRO_DONE;
					cal_step_d      = STEP_GYRO_END;
					phase_d         = PH_DONE;
				end
			end
			PH_MUL: begin
				cmd.mul = 1'b1;
				if (!dashing_q && !backing_off_q) begin
					cmd.fwd_sel = FWD_CRUISE;
				end
				phase_d = PH_CRASH;
			end
			PH_CRASH: begin
				cmd.turn_load = 1'b1;
				if (sts.crash_gyro && slope_armed_q && !backing_off_q) begin
					tone_d        = TONE_CRASH;
					backing_off_d = 1'b1;
					cmd.fwd_sel   = FWD_BACK;
					cmd.mark_load = 1'b1;
				end
				phase_d = PH_DASH;
			end
			PH_DASH: begin
				if (backing_off_q && sts.dash_window) begin
					tone_d      = TONE_DASH;
					cmd.fwd_sel = FWD_DASH;
					dashing_d   = 1'b1;
				end
				phase_d = PH_SUMMIT;
			end
			PH_SUMMIT: begin
				if (dashing_q && sts.summit_gyro) begin
					tone_d        = TONE_SUMMIT;
					cmd.fwd_sel   = FWD_CRUISE;
					cmd.mark_load = 1'b1;
				end
				phase_d = PH_CLEAR;
			end
			PH_CLEAR: begin
				if (dashing_q && sts.clear_window) begin
					dashing_d     = 1'b0;
					backing_off_d = 1'b0;
				end
				phase_d = PH_DONE;
			end
			PH_DONE: begin
				// hold until the result register frees up
				if (!result_valid_q || !result_stall) begin
					cmd.out_load = 1'b1;
					phase_d      = PH_IDLE;
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			cal_step_q     <= STEP_GYRO_START;
			tone_q         <= TONE_NONE;
			hold_to_ok_q   <= 1'b0;
			control_mode_q <= 1'b0;
			slope_armed_q  <= 1'b0;
			backing_off_q  <= 1'b0;
			dashing_q      <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			phase_q        <= phase_d;
			cal_step_q     <= cal_step_d;
			tone_q         <= tone_d;
			hold_to_ok_q   <= hold_to_ok_d;
			control_mode_q <= control_mode_d;
			slope_armed_q  <= slope_armed_d;
			backing_off_q  <= backing_off_d;
			dashing_q      <= dashing_d;
			result_valid_q <= cmd.out_load | (result_valid_q & result_stall);
		end
	end

	`LTCS_CHECK(a_step_range, cal_step_q <= STEP_HOLD, "calibration step out of range")
	`LTCS_IMPLY(a_mode_end, control_mode_q, cal_step_q == STEP_END, "control mode before end step")
	`LTCS_IMPLY(a_dash_backoff, dashing_q, backing_off_q, "dashing without backing off")
	`LTCS_IMPLY(a_div_step, cmd.div_start, cal_step_q == STEP_GYRO && !control_mode_q,
		"divide started outside gyro step")

endmodule

@@ hdl/line_trace_command_sequencer.sv @@
// Line trace command sequencer: calibration sequencer, line steering and slope logic.
// Uses ltcs_pkg, ltcs_cfg, ltcs_ctrl and ltcs_datapath.
//
// Usage:
//   item channel (item_valid, item_stall, item): one tick per item. Opcode 0 steps
//   calibration while not yet in control mode; opcode 1 runs steering and slope logic.
//   result channel (result_valid, result_stall, result): exactly one result per item.
//   cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data): register writes, always
//   ready; write only while the block holds no unfinished item.
// Sequencing: a steering item passes decode, multiply, crash, dash, summit, clear and
//   done; a calibration item decode, calibration and done; a control-mode opcode 0
//   item decode and done. The tick that closes the gyro window adds the 24-step
//   restoring divider. The block works on one item at a time; the next item is
//   accepted in the cycle after the previous one's result is loaded.
// A result register parts the two sides: while the receiver stalls, the next item is
//   still accepted and processed, and it waits for the register only at its last step.
// Reset clears all calibration state, levels, offset and commands to zero and loads
//   the configuration registers with their defaults; no result is pending after it.
module line_trace_command_sequencer
	import ltcs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  item_t               item,
	output logic                result_valid,
	input  logic                result_stall,
	output result_t             result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	ltcs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ltcs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	ltcs_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cfg    (cfg),
		.cmd    (cmd),
		.sts    (sts),
		.result (result)
	);

endmodule

@@ tb/sv/tb_line_trace_command_sequencer.sv @@
// Self-checking testbench for line_trace_command_sequencer: calibration, steering and slope logic.
// Depends on ltcs_pkg and the RTL; an in-bench predictor or known table rows check every result.
module tb_line_trace_command_sequencer;
	import ltcs_pkg::*;

	localparam logic OP_CAL   = 1'b0;
	localparam logic OP_STEER = 1'b1;

	localparam logic [3:0] ST_GYRO_START = 4'd0;
	localparam logic [3:0] ST_GYRO       = 4'd1;
	localparam logic [3:0] ST_GYRO_END   = 4'd2;
	localparam logic [3:0] ST_OK         = 4'd3;
	localparam logic [3:0] ST_OK_END     = 4'd4;
	localparam logic [3:0] ST_END        = 4'd5;
	localparam logic [3:0] ST_BLACK      = 4'd6;
	localparam logic [3:0] ST_WHITE      = 4'd7;
	localparam logic [3:0] ST_HOLD       = 4'd8;

	localparam logic [2:0] TONE_NONE   = 3'd0;
	localparam logic [2:0] TONE_START  = 3'd1;
	localparam logic [2:0] TONE_GYRO   = 3'd2;
	localparam logic [2:0] TONE_CAPT   = 3'd3;
	localparam logic [2:0] TONE_CRASH  = 3'd4;
	localparam logic [2:0] TONE_DASH   = 3'd5;
	localparam logic [2:0] TONE_SUMMIT = 3'd6;

	localparam int REG_GAIN       = 0;
	localparam int REG_CRUISE     = 1;
	localparam int REG_DASH       = 2;
	localparam int REG_SLOPE_LIM  = 3;
	localparam int REG_SUMMIT_LIM = 4;
	localparam int REG_BACK_MIN   = 5;
	localparam int REG_BACK_MAX   = 6;
	localparam int REG_WINDOW     = 7;

	localparam logic [13:0]       COUNT_MAX    = 14'd16383;
	localparam logic signed [7:0] BACKOFF_FWD  = -8'sd20;
	localparam longint            CLEAR_COUNTS = 90;
	localparam int                TURN_LIMIT   = 100;
	localparam longint            WHEEL_MAX    = 64'sd2147483647;
	localparam longint            WHEEL_MIN    = -64'sd2147483648;
	localparam int                DRAIN_CYCLES = 40;
	localparam int                CHUNKS       = 8;
	localparam int                CHUNK_ITEMS  = 75;

	localparam cfg_t CFG_RESET  = '{10'd179, 7'd20, 7'd75, 10'd650, 10'd700,
		12'd90, 12'd720, 14'd1000};
	localparam cfg_t CFG_WIDE   = '{10'd1023, 7'd100, 7'd100, 10'd0, 10'd0,
		12'd0, 12'd4095, 14'd10000};
	localparam cfg_t CFG_NARROW = '{10'd0, 7'd0, 7'd0, 10'd1023, 10'd1023,
		12'd4095, 12'd0, 14'd1};

	typedef struct packed {
		logic    known;
		item_t   stim;
		result_t want;
	} dir_row_t;

	localparam int DIR_ROWS = 11;
	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		'{1'b1, '{OP_CAL, 1'b0, 10'd0, 10'd0, 32'sd0, 32'd0},
			'{8'sd0, 8'sd0, 1'b0, 10'd0, TONE_NONE, ST_GYRO_START}},
		'{1'b1, '{OP_STEER, 1'b0, 10'd1023, 10'd0, 32'sh7FFF_FFFF, 32'd1},
			'{8'sd20, 8'sd0, 1'b0, 10'd0, TONE_NONE, ST_GYRO_START}},
		'{1'b1, '{OP_STEER, 1'b1, 10'd0, 10'd1023, 32'sh8000_0000, 32'd2},
			'{8'sd20, -8'sd100, 1'b0, 10'd0, TONE_NONE, ST_GYRO_START}},
		'{1'b1, '{OP_STEER, 1'b0, 10'd1023, 10'd1, 32'sd0, 32'd3},
			'{8'sd20, 8'sd0, 1'b0, 10'd0, TONE_NONE, ST_GYRO_START}},
		'{1'b0, '{OP_STEER, 1'b1, 10'd651, 10'd2, -32'sd1, 32'd4}, '0},
		'{1'b0, '{OP_STEER, 1'b0, 10'd650, 10'd143, 32'sd100, 32'd5}, '0},
		'{1'b0, '{OP_STEER, 1'b0, 10'd700, 10'd144, -32'sd100, 32'd6}, '0},
		'{1'b1, '{OP_CAL, 1'b0, 10'd1023, 10'd1023, -32'sd1, 32'hFFFF_FFFF},
			'{8'sd0, 8'sd0, 1'b0, 10'd0, TONE_NONE, ST_GYRO_START}},
		'{1'b0, '{OP_STEER, 1'b1, 10'd512, 10'd512, 32'sh5555_5555, 32'hAAAA_AAAA}, '0},
		'{1'b0, '{OP_STEER, 1'b0, 10'd341, 10'd682, 32'shAAAA_AAAA, 32'h5555_5555}, '0},
		'{1'b1, '{OP_CAL, 1'b0, 10'd0, 10'd0, 32'sd0, 32'h8000_0000},
			'{8'sd0, 8'sd0, 1'b0, 10'd0, TONE_NONE, ST_GYRO_START}}
	};

	logic                clk;
	logic                arst_n;
	logic                item_valid;
	logic                item_stall;
	item_t               item;
	logic                result_valid;
	logic                result_stall;
	result_t             result;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	// Predictor copy of the block's state and registers
	cfg_t              regs;
	logic              ctl_mode;
	logic [3:0]        cal_step;
	logic [31:0]       step_t0;
	logic [23:0]       gsum;
	logic [13:0]       gcount;
	logic [9:0]        offset;
	logic [9:0]        black_lvl;
	logic [9:0]        white_lvl;
	logic              armed;
	logic              backing;
	logic              dashing;
	logic              hold_ok;
	longint            mark;
	logic signed [7:0] fwd;
	logic signed [7:0] turn;

	result_t pending_results[$];
	result_t mon_want;
	int      errors;
	logic    quiet;
	logic [31:0] now_ms;
	longint  pos;
	int      gyro_extra;
	int      row;
	int      chunk;
	cfg_t    setting;

	line_trace_command_sequencer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic result_t predict_commands(input item_t it);
		result_t     r;
		logic [2:0]  tone;
		logic [31:0] elapsed;
		longint      w;
		int          dev;
		int          prod;
		int          tq;
		tone = TONE_NONE;
		elapsed = it.time_ms - step_t0;
		w = longint'($signed(it.wheel_count));
		if (it.opcode == OP_CAL) begin
			if (!ctl_mode) begin
				case (cal_step)
				ST_GYRO_START: begin
					if (it.touch_pressed) begin
						tone = TONE_START;
						gsum = '0;
						gcount = '0;
						step_t0 = it.time_ms;
						cal_step = ST_GYRO;
					end
				end
				ST_GYRO: begin
					if (gcount < COUNT_MAX) begin
						gsum = gsum + 24'(it.gyro_sample);
						gcount = gcount + 14'd1;
					end
					if (elapsed >= 32'(regs.window_ms)) begin
						offset = 10'(gsum / 24'(gcount));
						tone = TONE_GYRO;
						cal_step = ST_GYRO_END;
					end
				end
				ST_GYRO_END: begin
					if (!it.touch_pressed)
						cal_step = ST_BLACK;
				end
				ST_BLACK, ST_WHITE: begin
					if (it.touch_pressed) begin
						if (cal_step == ST_BLACK) begin
							black_lvl = it.light_sample;
							hold_ok = 1'b0;
						end else begin
							white_lvl = it.light_sample;
							hold_ok = 1'b1;
						end
						tone = TONE_CAPT;
						step_t0 = it.time_ms;
						cal_step = ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (elapsed >= 32'(regs.window_ms))
						cal_step = hold_ok ? ST_OK : ST_WHITE;
				end
				ST_OK: begin
					if (it.touch_pressed) begin
						tone = TONE_START;
						cal_step = ST_OK_END;
					end
				end
				ST_OK_END: begin
					if (!it.touch_pressed) begin
						tone = TONE_START;
						cal_step = ST_END;
					end
				end
				ST_END: begin
					ctl_mode = 1'b1;
					armed = 1'b1;
				end
				default: ;
				endcase
				fwd = '0;
				turn = '0;
			end
		end else begin
			dev = int'((11'(black_lvl) + 11'(white_lvl)) >> 1) - int'(it.light_sample);
			prod = int'(regs.steer_gain_q8) * dev;
			tq = prod / 256;
			if (tq > TURN_LIMIT)
				tq = TURN_LIMIT;
			if (tq < -TURN_LIMIT)
				tq = -TURN_LIMIT;
			turn = 8'(tq);
			if (!dashing && !backing)
				fwd = 8'(regs.cruise_speed);
			if (it.gyro_sample > regs.slope_gyro_limit && armed && !backing) begin
				tone = TONE_CRASH;
				backing = 1'b1;
				fwd = BACKOFF_FWD;
				mark = w;
			end
			if (backing && w < mark - longint'(regs.backoff_min_counts) &&
					w > mark - longint'(regs.backoff_max_counts)) begin
				tone = TONE_DASH;
				fwd = 8'(regs.dash_speed);
				dashing = 1'b1;
			end
			if (dashing && it.gyro_sample > regs.summit_gyro_limit) begin
				tone = TONE_SUMMIT;
				fwd = 8'(regs.cruise_speed);
				mark = w;
			end
			if (dashing && w > mark + CLEAR_COUNTS) begin
				dashing = 1'b0;
				backing = 1'b0;
			end
		end
		r.forward_cmd = fwd;
		r.turn_cmd = turn;
		r.in_control = ctl_mode;
		r.offset_value = offset;
		r.tone_code = tone;
		r.step_code = cal_step;
		return r;
	endfunction

	// Calibration tick that follows the sequence most of the time
	function automatic item_t next_cal_item();
		item_t it;
		it.opcode = ($urandom_range(0, 15) == 0) ? OP_STEER : OP_CAL;
		it.gyro_sample = 10'($urandom);
		it.light_sample = 10'($urandom);
		it.wheel_count = $urandom;
		it.touch_pressed = 1'($urandom);
		case (cal_step)
		ST_GYRO_START, ST_BLACK, ST_WHITE, ST_OK:
			it.touch_pressed = ($urandom_range(0, 2) == 0);
		ST_GYRO_END, ST_OK_END:
			it.touch_pressed = ($urandom_range(0, 2) != 0);
		default: ;
		endcase
		if (cal_step == ST_GYRO) begin
			// hold time for a few ticks, then step across the window edge
			gyro_extra++;
			if (gyro_extra > 4)
				now_ms = step_t0 + 32'(regs.window_ms);
			else if (gyro_extra == 4)
				now_ms = step_t0 + 32'(regs.window_ms) - 32'd1;
			else
				now_ms = step_t0;
		end else begin
			now_ms = now_ms + $urandom_range(0, 2);
		end
		it.time_ms = now_ms;
		return it;
	endfunction

	// Steering tick that walks the slope sequence: spike, back off, dash, summit, clear
	function automatic item_t next_slope_item();
		item_t      it;
		logic [9:0] lim;
		logic [9:0] mid;
		logic       hit;
		int         v;
		it.opcode = ($urandom_range(0, 11) == 0) ? OP_CAL : OP_STEER;
		it.touch_pressed = 1'($urandom);
		mid = 10'((11'(black_lvl) + 11'(white_lvl)) >> 1);
		v = int'(mid) + int'($urandom_range(0, 300)) - 150;
		if (v < 0)
			v = 0;
		if (v > 1023)
			v = 1023;
		it.light_sample = $urandom_range(0, 1) ? 10'($urandom) : 10'(v);
		lim = dashing ? regs.summit_gyro_limit : regs.slope_gyro_limit;
		hit = dashing ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 9) == 0)
			it.gyro_sample = 10'($urandom);
		else if (hit && lim != 10'd1023)
			it.gyro_sample = 10'($urandom_range(int'(lim) + 1, 1023));
		else if ($urandom_range(0, 4) == 0)
			it.gyro_sample = lim;
		else
			it.gyro_sample = 10'($urandom_range(0, int'(lim)));
		if (backing && !dashing)
			pos = pos - longint'($urandom_range(0, 90));
		else if (dashing)
			pos = pos + longint'($urandom_range(0, 45));
		else
			pos = pos + longint'($urandom_range(0, 40)) - 20;
		if (pos > WHEEL_MAX)
			pos = WHEEL_MAX;
		if (pos < WHEEL_MIN)
			pos = WHEEL_MIN;
		it.wheel_count = ($urandom_range(0, 19) == 0) ? $urandom : 32'(pos);
		now_ms = now_ms + $urandom_range(1, 20);
		it.time_ms = now_ms;
		return it;
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance
	task automatic send_item(input item_t it, input logic known, input result_t want);
		result_t pred;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		pred = predict_commands(it);
		pending_results.push_back(known ? want : pred);
		@(negedge clk);
	endtask

	task automatic drain_results();
		item_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic program_cfg(input cfg_t c);
		int                  i;
		logic [CfgDataW-1:0] val;
		for (i = REG_GAIN; i <= REG_WINDOW; i++) begin
			case (i)
			REG_GAIN:       val = CfgDataW'(c.steer_gain_q8);
			REG_CRUISE:     val = CfgDataW'(c.cruise_speed);
			REG_DASH:       val = CfgDataW'(c.dash_speed);
			REG_SLOPE_LIM:  val = CfgDataW'(c.slope_gyro_limit);
			REG_SUMMIT_LIM: val = CfgDataW'(c.summit_gyro_limit);
			REG_BACK_MIN:   val = CfgDataW'(c.backoff_min_counts);
			REG_BACK_MAX:   val = CfgDataW'(c.backoff_max_counts);
			default:        val = CfgDataW'(c.window_ms);
			endcase
			cfg_valid <= 1'b1;
			cfg_index <= CfgIdxW'(i);
			cfg_data <= val;
			do @(posedge clk); while (!cfg_ready);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
		regs = c;
	endtask

	// Receiver stalls in bursts, with free stretches between them
	initial begin
		result_stall = 1'b0;
		forever begin
			repeat ($urandom_range(1, 30)) @(negedge clk);
			if (!quiet) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(negedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				$error("result arrived with no item outstanding");
				errors++;
			end else begin
				mon_want = pending_results.pop_front();
				if (result.forward_cmd !== mon_want.forward_cmd) begin
					$error("forward_cmd: expected %0d, got %0d",
						mon_want.forward_cmd, result.forward_cmd);
					errors++;
				end
				if (result.turn_cmd !== mon_want.turn_cmd) begin
					$error("turn_cmd: expected %0d, got %0d", mon_want.turn_cmd, result.turn_cmd);
					errors++;
				end
				if (result.in_control !== mon_want.in_control) begin
					$error("in_control: expected %0d, got %0d",
						mon_want.in_control, result.in_control);
					errors++;
				end
				if (result.offset_value !== mon_want.offset_value) begin
					$error("offset_value: expected %0d, got %0d",
						mon_want.offset_value, result.offset_value);
					errors++;
				end
				if (result.tone_code !== mon_want.tone_code) begin
					$error("tone_code: expected %0d, got %0d",
						mon_want.tone_code, result.tone_code);
					errors++;
				end
				if (result.step_code !== mon_want.step_code) begin
					$error("step_code: expected %0d, got %0d",
						mon_want.step_code, result.step_code);
					errors++;
				end
			end
		end
	end

	initial begin
		#40_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		quiet = 1'b0;
		now_ms = '0;
		pos = 0;
		gyro_extra = 0;
		regs = CFG_RESET;
		ctl_mode = 1'b0;
		cal_step = ST_GYRO_START;
		step_t0 = '0;
		gsum = '0;
		gcount = '0;
		offset = '0;
		black_lvl = '0;
		white_lvl = '0;
		armed = 1'b0;
		backing = 1'b0;
		dashing = 1'b0;
		hold_ok = 1'b0;
		mark = 0;
		fwd = '0;
		turn = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (row = 0; row < DIR_ROWS; row++)
			send_item(DIR_TABLE[row].stim, DIR_TABLE[row].known, DIR_TABLE[row].want);

		// Longest window, started just short of the time wrap
		drain_results();
		setting = CFG_RESET;
		setting.window_ms = 14'd10000;
		program_cfg(setting);
		now_ms = 32'hFFFF_E000;
		while (!ctl_mode) begin
			if (cal_step == ST_BLACK && regs.window_ms != 14'd0 && black_lvl == '0 &&
					offset != '0) begin
				// zero window: the black hold completes on its first tick
				drain_results();
				setting = regs;
				setting.window_ms = 14'd0;
				program_cfg(setting);
			end
			if (cal_step == ST_WHITE && regs.window_ms == 14'd0) begin
				drain_results();
				setting = regs;
				setting.window_ms = 14'd1;
				program_cfg(setting);
			end
			send_item(next_cal_item(), 1'b0, '0);
		end

		for (chunk = 0; chunk < CHUNKS; chunk++) begin
			drain_results();
			case (chunk)
			0: setting = CFG_RESET;
			1: setting = CFG_WIDE;
			2: setting = CFG_NARROW;
			default: begin
				setting.steer_gain_q8 = 10'($urandom_range(0, 1023));
				setting.cruise_speed = 7'($urandom_range(0, 100));
				setting.dash_speed = 7'($urandom_range(0, 100));
				setting.slope_gyro_limit = 10'($urandom_range(300, 900));
				setting.summit_gyro_limit = 10'($urandom_range(300, 900));
				setting.backoff_min_counts = 12'($urandom_range(0, 200));
				setting.backoff_max_counts = 12'($urandom_range(150, 1200));
				setting.window_ms = 14'($urandom_range(1, 10000));
			end
			endcase
			program_cfg(setting);
			// push the wheel toward the ends of its range
			if (chunk == 1)
				pos = WHEEL_MIN + 300;
			else if (chunk == 3)
				pos = WHEEL_MAX - 60;
			quiet = (chunk == CHUNKS - 1);
			repeat (CHUNK_ITEMS) send_item(next_slope_item(), 1'b0, '0);
		end
		drain_results();

		if (errors == 0 && pending_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/ltcs_pkg.sv
hdl/ltcs_cfg.sv
hdl/ltcs_div.sv
hdl/ltcs_datapath.sv
hdl/ltcs_ctrl.sv
hdl/line_trace_command_sequencer.sv
tb/sv/tb_line_trace_command_sequencer.sv
